### design/assert_macros.svh
// Assertion macros shared by the detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst_n, cond, expect_expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_expr)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expect_expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_expr)) \
        else $error(msg);

`endif

### design/imd_pkg.sv
// Types, constants and register codes for the motion and hover detector.
package imd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HOLD_W = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int MOVE_LANES = 6;
    localparam int HOVER_LANES = 2;

    localparam int MOVE_WINDOW_DEF = 10;
    localparam int HOVER_WINDOW_DEF = 100;

    localparam logic [SAMPLE_W-1:0] MOVE_THR_RST = 16'd80;
    localparam logic [HOLD_W-1:0] STEADY_HOLD_RST = 8'd25;
    localparam logic [SAMPLE_W-1:0] HOVER_THR_RST = 16'd1000;
    localparam logic [HOLD_W-1:0] GROUND_HOLD_RST = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MOVE_THR    = 8'd0,
        REG_STEADY_HOLD = 8'd1,
        REG_HOVER_THR   = 8'd2,
        REG_GROUND_HOLD = 8'd3
    } imd_reg_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
    } imd_sample_t;

    typedef struct packed {
        logic moving;
        logic hovering;
        logic move_window_full;
        logic hover_window_full;
    } imd_result_t;

    // Pipeline control handed to each delay line.
    typedef struct packed {
        logic load;
        logic advance;
    } imd_step_t;

endpackage

### design/imd_line.sv
// One delay line with its difference, maximum and hold-counter logic.
`include "assert_macros.svh"

module imd_line import imd_pkg::*; #(
    parameter int DEPTH = MOVE_WINDOW_DEF,
    parameter int LANES = MOVE_LANES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  imd_step_t                       step,
    input  logic [LANES-1:0][SAMPLE_W-1:0]  sample,
    input  logic [SAMPLE_W-1:0]             threshold,
    input  logic [HOLD_W-1:0]               hold,
    output logic                            flag_next,
    output logic                            full
);

    localparam int POS_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

    logic [LANES-1:0][SAMPLE_W-1:0] mem [DEPTH];
    logic [LANES-1:0][SAMPLE_W-1:0] old_reg;
    logic [LANES-1:0][SAMPLE_W-1:0] sample_reg;
    logic [POS_W-1:0]               pos_reg;
    logic [FILL_W-1:0]              fill_reg;
    logic                           full_reg;
    logic [HOLD_W-1:0]              count_reg;
    logic [HOLD_W-1:0]              count_next;
    logic                           flag_reg;
    logic [SAMPLE_W-1:0]            peak_gap;

    // The read returns the entry from one window back before the new sample replaces it.
    always_ff @(posedge clk)
    begin
        if (step.load)
        begin
            old_reg <= mem[pos_reg];
            mem[pos_reg] <= sample;
            sample_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            fill_reg  <= '0;
            full_reg  <= 1'b0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else
        begin
            if (step.load)
            begin
                pos_reg  <= (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                full_reg <= (fill_reg == FILL_MAX);
                if (fill_reg != FILL_MAX)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (step.advance)
            begin
                count_reg <= count_next;
                flag_reg  <= flag_next;
            end
        end
    end

    always_comb
    begin
        logic signed [SAMPLE_W:0] diff;
        logic [SAMPLE_W:0] mag;
        peak_gap = '0;
        for (int i = 0; i < LANES; i++)
        begin
            diff = $signed({sample_reg[i][SAMPLE_W-1], sample_reg[i]})
                 - $signed({old_reg[i][SAMPLE_W-1], old_reg[i]});
            mag = diff[SAMPLE_W] ? (SAMPLE_W+1)'(-diff) : diff;
            if (mag[SAMPLE_W-1:0] > peak_gap)
            begin
                peak_gap = mag[SAMPLE_W-1:0];
            end
        end
    end

    // Flag and counter change only when a comparison took place.
    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        if (full_reg)
        begin
            priority if (peak_gap > threshold)
            begin
                flag_next  = 1'b1;
                count_next = hold;
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
            else
            begin
                flag_next = 1'b0;
            end
        end
    end

    assign full = full_reg;

    `ASSERT_SAME(a_count_implies_flag, clk, rst_n, count_reg != '0, flag_reg,
        "hold counter running while the flag is clear")
    `ASSERT_SAME(a_full_matches_fill, clk, rst_n, full_reg, fill_reg == FILL_MAX,
        "comparison marked while the line is not yet full")
    `ASSERT_SAME(a_pos_in_range, clk, rst_n, 1'b1, pos_reg <= POS_LAST,
        "write position ran past the end of the line")

endmodule

### design/imu_motion_hover_detector.sv
// Top level of the IMU motion and hover detector.
// Each delay line has one write and one registered read. A result passes through the
// compare stage into the output register. Throughput: one sample per cycle unless stalled.
// Reset clears positions, fill counts, hold counters, flags and the pipeline registers,
// and restores the configuration defaults; history is not cleared.
`include "assert_macros.svh"

module imu_motion_hover_detector import imd_pkg::*; #(
    parameter int MOVE_WINDOW = MOVE_WINDOW_DEF,
    parameter int HOVER_WINDOW = HOVER_WINDOW_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  imd_sample_t             in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output imd_result_t             out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    logic [SAMPLE_W-1:0]  move_thr_reg;
    logic [HOLD_W-1:0]    steady_hold_reg;
    logic [SAMPLE_W-1:0]  hover_thr_reg;
    logic [HOLD_W-1:0]    ground_hold_reg;

    logic         stage_valid_reg;
    logic         out_valid_reg;
    imd_result_t  result_reg;
    imd_step_t    step;

    logic [MOVE_LANES-1:0][SAMPLE_W-1:0]  move_sample;
    logic [HOVER_LANES-1:0][SAMPLE_W-1:0] hover_sample;
    logic moving_next;
    logic hovering_next;
    logic move_full;
    logic hover_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_thr_reg    <= MOVE_THR_RST;
            steady_hold_reg <= STEADY_HOLD_RST;
            hover_thr_reg   <= HOVER_THR_RST;
            ground_hold_reg <= GROUND_HOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MOVE_THR:    move_thr_reg    <= cfg_data;
                REG_STEADY_HOLD: steady_hold_reg <= cfg_data[HOLD_W-1:0];
                REG_HOVER_THR:   hover_thr_reg   <= cfg_data;
                REG_GROUND_HOLD: ground_hold_reg <= cfg_data[HOLD_W-1:0];
                default:         ;
            endcase
        end
    end

    // The compare stage moves on whenever the output register is free or being emptied.
    assign step.advance = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = stage_valid_reg && !step.advance;
    assign step.load = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            result_reg      <= '0;
        end
        else
        begin
            if (step.load)
            begin
                stage_valid_reg <= 1'b1;
            end
            else if (step.advance)
            begin
                stage_valid_reg <= 1'b0;
            end

            if (step.advance)
            begin
                out_valid_reg                <= 1'b1;
                result_reg.moving            <= moving_next;
                result_reg.hovering          <= hovering_next;
                result_reg.move_window_full  <= move_full;
                result_reg.hover_window_full <= hover_full;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign move_sample = {in_data.gyro_z, in_data.gyro_y, in_data.gyro_x,
                          in_data.accel_z, in_data.accel_y, in_data.accel_x};
    assign hover_sample = {in_data.gyro_y, in_data.gyro_x};

    imd_line #(
        .DEPTH (MOVE_WINDOW),
        .LANES (MOVE_LANES)
    ) u_move_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .sample    (move_sample),
        .threshold (move_thr_reg),
        .hold      (steady_hold_reg),
        .flag_next (moving_next),
        .full      (move_full)
    );

    imd_line #(
        .DEPTH (HOVER_WINDOW),
        .LANES (HOVER_LANES)
    ) u_hover_line (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .sample    (hover_sample),
        .threshold (hover_thr_reg),
        .hold      (ground_hold_reg),
        .flag_next (hovering_next),
        .full      (hover_full)
    );

    assign out_valid = out_valid_reg;
    assign out_data = result_reg;

    `ASSERT_NEXT(a_stage_holds, clk, rst_n, stage_valid_reg && !step.advance, stage_valid_reg,
        "compare stage dropped a sample it could not pass on")
    `ASSERT_NEXT(a_advance_fills_out, clk, rst_n, step.advance, out_valid_reg,
        "advanced sample did not reach the output register")
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && out_stall,
        out_valid_reg && $stable(result_reg),
        "stalled result changed or disappeared")

endmodule
